// ----- src/v6lpm_pkg.sv -----
// Package for the IPv6 longest prefix route lookup.
// Holds word layouts, opcodes, FSM states, controller/datapath links and the metric ranking.
// No dependencies.
package v6lpm_pkg;

    localparam int DEF_NUM_ROUTES = 64;
    localparam int ENTRY_W        = 6;
    localparam int ADDR_W         = 128;
    localparam int PREFIX_W       = 8;
    localparam int METRIC_W       = 32;
    localparam int IFNUM_W        = 8;
    localparam int OPCODE_W       = 2;

    localparam logic [PREFIX_W-1:0] MAX_PREFIX = 8'd128;
    localparam logic [METRIC_W-1:0] WORST_RANK = 32'h7FFF_FFFF;

    // input word: entry, addr high, addr low, prefix, metric, hop high, hop low, interface
    localparam int IN_ENTRY_LSB  = 0;
    localparam int IN_AHI_LSB    = IN_ENTRY_LSB + ENTRY_W;
    localparam int IN_ALO_LSB    = IN_AHI_LSB + 64;
    localparam int IN_PFX_LSB    = IN_ALO_LSB + 64;
    localparam int IN_MET_LSB    = IN_PFX_LSB + PREFIX_W;
    localparam int IN_NHI_LSB    = IN_MET_LSB + METRIC_W;
    localparam int IN_NLO_LSB    = IN_NHI_LSB + 64;
    localparam int IN_IF_LSB     = IN_NLO_LSB + 64;
    localparam int IN_USED_W     = IN_IF_LSB + IFNUM_W;
    localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // output word: index, prefix, metric, hop high, hop low, interface
    localparam int OUT_USED_W    = ENTRY_W + PREFIX_W + METRIC_W + ADDR_W + IFNUM_W;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_USED_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOOKUP     = 2'd0,
        OP_WRITE      = 2'd1,
        OP_INVALIDATE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [PREFIX_W-1:0] prefix;
        logic [METRIC_W-1:0] metric;
        logic [ADDR_W-1:0]   next_hop;
        logic [IFNUM_W-1:0]  ifnum;
    } t_route;

    typedef struct packed {
        logic start;
        logic write;
        logic invalidate;
        logic scan_step;
        logic load_zero;
        logic load_best;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic scan_last;
    } t_dp_status;

    function automatic logic [METRIC_W-1:0] rank_metric(input logic [METRIC_W-1:0] raw);
        rank_metric = raw[METRIC_W-1] ? WORST_RANK : raw;
    endfunction

endpackage

// ----- src/v6lpm_ctrl.sv -----
// Controller FSM for the route lookup: sequences accepts, table scans and result loads.
// Depends on v6lpm_pkg.
module v6lpm_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [v6lpm_pkg::OPCODE_W-1:0]      i_opcode,
    input  v6lpm_pkg::t_dp_status               i_status,
    output v6lpm_pkg::t_dp_cmd                  o_cmd
);

    v6lpm_pkg::t_state r_state;
    v6lpm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= v6lpm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        case (r_state)
            v6lpm_pkg::ST_IDLE: begin
                s_axis_tready = i_status.out_free;
                if (s_axis_tvalid && i_status.out_free) begin
                    case (v6lpm_pkg::t_opcode'(i_opcode))
                        v6lpm_pkg::OP_LOOKUP: begin
                            o_cmd.start = 1'b1;
                            n_state     = v6lpm_pkg::ST_SCAN;
                        end
                        v6lpm_pkg::OP_WRITE: begin
                            o_cmd.write     = 1'b1;
                            o_cmd.load_zero = 1'b1;
                        end
                        v6lpm_pkg::OP_INVALIDATE: begin
                            o_cmd.invalidate = 1'b1;
                            o_cmd.load_zero  = 1'b1;
                        end
                        default: begin
                            o_cmd.load_zero = 1'b1;
                        end
                    endcase
                end
            end
            v6lpm_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = v6lpm_pkg::ST_LAST;
                end
            end
            v6lpm_pkg::ST_LAST: begin
                n_state = v6lpm_pkg::ST_DONE;
            end
            v6lpm_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_best = 1'b1;
                    n_state         = v6lpm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = v6lpm_pkg::ST_IDLE;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == v6lpm_pkg::ST_IDLE))
        else $error("ready raised outside idle");

    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == v6lpm_pkg::ST_LAST) |=> (r_state == v6lpm_pkg::ST_DONE))
        else $error("final compare not followed by result load");

endmodule

// ----- src/v6lpm_dp.sv -----
// Datapath for the route lookup: route memory, valid bits, scan pipeline, best route and output register.
// Depends on v6lpm_pkg; driven by v6lpm_ctrl.
module v6lpm_dp #(
    parameter int NUM_ROUTES = v6lpm_pkg::DEF_NUM_ROUTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [v6lpm_pkg::IN_DATA_W-1:0]     i_tdata,
    input  v6lpm_pkg::t_dp_cmd                  i_cmd,
    output v6lpm_pkg::t_dp_status               o_status,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [v6lpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [0:0]                          m_axis_tuser
);

    localparam int SLOTS = 2 ** v6lpm_pkg::ENTRY_W;
    localparam int DEPTH = (NUM_ROUTES < SLOTS) ? NUM_ROUTES : SLOTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [v6lpm_pkg::ADDR_W-1:0] KEY_ONES = '1;

    v6lpm_pkg::t_route                  r_mem [DEPTH];
    logic [DEPTH-1:0]                   r_valid;

    logic [v6lpm_pkg::ADDR_W-1:0]       r_key;
    logic [IDX_W-1:0]                   r_scan_idx;
    v6lpm_pkg::t_route                  r_rd_data;
    logic                               r_rd_hit;
    logic [IDX_W-1:0]                   r_rd_idx;
    logic                               r_rd_live;

    logic                               r_have;
    logic [IDX_W-1:0]                   r_best_idx;
    logic [v6lpm_pkg::METRIC_W-1:0]     r_best_rank;
    v6lpm_pkg::t_route                  r_best;

    logic                               r_out_valid;
    logic                               r_out_found;
    logic [v6lpm_pkg::OUT_DATA_W-1:0]   r_out_data;

    logic [v6lpm_pkg::ENTRY_W-1:0]      w_entry;
    logic                               w_slot_ok;
    logic [IDX_W-1:0]                   w_slot;
    logic [v6lpm_pkg::PREFIX_W-1:0]     w_prefix_in;
    v6lpm_pkg::t_route                  w_route;
    logic [v6lpm_pkg::ADDR_W-1:0]       w_mask;
    logic [v6lpm_pkg::METRIC_W-1:0]     w_rank;
    logic                               w_hit;
    logic                               w_better;
    logic [v6lpm_pkg::OUT_DATA_W-1:0]   w_best_word;

    assign w_entry     = i_tdata[v6lpm_pkg::IN_ENTRY_LSB +: v6lpm_pkg::ENTRY_W];
    assign w_slot_ok   = ({1'b0, w_entry} < (v6lpm_pkg::ENTRY_W + 1)'(DEPTH));
    assign w_slot      = w_entry[IDX_W-1:0];
    assign w_prefix_in = i_tdata[v6lpm_pkg::IN_PFX_LSB +: v6lpm_pkg::PREFIX_W];

    always_comb begin
        w_route.dest     = {i_tdata[v6lpm_pkg::IN_AHI_LSB +: 64],
                            i_tdata[v6lpm_pkg::IN_ALO_LSB +: 64]};
        w_route.prefix   = (w_prefix_in > v6lpm_pkg::MAX_PREFIX) ? v6lpm_pkg::MAX_PREFIX
                                                                 : w_prefix_in;
        w_route.metric   = i_tdata[v6lpm_pkg::IN_MET_LSB +: v6lpm_pkg::METRIC_W];
        w_route.next_hop = {i_tdata[v6lpm_pkg::IN_NHI_LSB +: 64],
                            i_tdata[v6lpm_pkg::IN_NLO_LSB +: 64]};
        w_route.ifnum    = i_tdata[v6lpm_pkg::IN_IF_LSB +: v6lpm_pkg::IFNUM_W];
    end

    // route memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && w_slot_ok) begin
            r_mem[w_slot] <= w_route;
        end
        r_rd_data <= r_mem[r_scan_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write && w_slot_ok) begin
            r_valid[w_slot] <= 1'b1;
        end else if (i_cmd.invalidate && w_slot_ok) begin
            r_valid[w_slot] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= {i_tdata[v6lpm_pkg::IN_AHI_LSB +: 64], i_tdata[v6lpm_pkg::IN_ALO_LSB +: 64]};
        end
        r_rd_hit <= r_valid[r_scan_idx];
        r_rd_idx <= r_scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_rd_live  <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.scan_step;
            if (i_cmd.start) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
        end
    end

    assign o_status.scan_last = (r_scan_idx == IDX_W'(DEPTH - 1));

    // compare stage: hold the best matching entry seen so far
    assign w_mask   = ~(KEY_ONES >> r_rd_data.prefix);
    assign w_rank   = v6lpm_pkg::rank_metric(r_rd_data.metric);
    assign w_hit    = r_rd_live && r_rd_hit && (((r_key ^ r_rd_data.dest) & w_mask) == '0);
    assign w_better = !r_have || (r_rd_data.prefix > r_best.prefix)
                   || ((r_rd_data.prefix == r_best.prefix) && (w_rank < r_best_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.start) begin
            r_have <= 1'b0;
        end else if (w_hit && w_better) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit && w_better && !i_cmd.start) begin
            r_best_idx  <= r_rd_idx;
            r_best_rank <= w_rank;
            r_best      <= r_rd_data;
        end
    end

    assign w_best_word = r_have ? {{v6lpm_pkg::OUT_PAD_W{1'b0}},
                                   r_best.ifnum,
                                   r_best.next_hop[63:0],
                                   r_best.next_hop[127:64],
                                   r_best.metric,
                                   r_best.prefix,
                                   v6lpm_pkg::ENTRY_W'(r_best_idx)}
                                : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_zero || i_cmd.load_best) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_best) begin
            r_out_found <= r_have;
            r_out_data  <= w_best_word;
        end else if (i_cmd.load_zero) begin
            r_out_found <= 1'b0;
            r_out_data  <= '0;
        end
    end

    assign o_status.out_free = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid     = r_out_valid;
    assign m_axis_tdata      = r_out_data;
    assign m_axis_tuser      = r_out_found;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_zero || i_cmd.load_best) |-> (!r_out_valid || m_axis_tready))
        else $error("output word overwritten before taken");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_best |-> !r_rd_live)
        else $error("result loaded while compare stage busy");

endmodule

// ----- src/ipv6_longest_prefix_route_lookup.sv -----
// Top level of the IPv6 longest prefix route lookup.
// Depends on v6lpm_pkg, v6lpm_ctrl and v6lpm_dp.
//
// channel  dir  handshake                    word
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata 312 b, tuser opcode
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata 184 b, tuser found
//
// A write or invalidate loads an all-zero result word on accept; a lookup reads one route
// per cycle from the route memory, then loads the best match as the result.
// Reset clears the valid bits at once; there is no clearing pass.
// The output register holds a result under back-pressure; a new word is taken
// only in idle while that register is empty or being emptied.
module ipv6_longest_prefix_route_lookup #(
    parameter int NUM_ROUTES = v6lpm_pkg::DEF_NUM_ROUTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index, addr_high, addr_low, prefix_length, metric_value,
    // next_hop_high, next_hop_low, interface_number, zero pad
    input  logic [v6lpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // opcode
    input  logic [v6lpm_pkg::OPCODE_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // matched_index, matched_prefix, matched_metric, result_next_high,
    // result_next_low, result_interface, zero pad
    output logic [v6lpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // found
    output logic [0:0]                          m_axis_tuser
);

    v6lpm_pkg::t_dp_cmd    w_cmd;
    v6lpm_pkg::t_dp_status w_status;

    v6lpm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_opcode      (s_axis_tuser),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    v6lpm_dp #(
        .NUM_ROUTES (NUM_ROUTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tdata       (s_axis_tdata),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
